@@ hw/rtl/top_k_by_length_tracker_assert.svh @@
// Assertion macros shared by the tracker checker.
`ifndef TOP_K_BY_LENGTH_TRACKER_ASSERT_SVH
`define TOP_K_BY_LENGTH_TRACKER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define TKL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is followed in the next cycle by a consequence.
`define TKL_ASSERT_NEXT(lbl, cond, cons, msg) \
	`TKL_ASSERT(lbl, (cond) |=> (cons), msg)

`endif

@@ hw/rtl/tkl_pkg.sv @@
// Shared types and constants of the top-k length tracker.
`timescale 1ns / 1ps

package tkl_pkg;

	localparam int LEN_W        = 16;
	localparam int ID_W         = 31;
	localparam int RANK_W       = 4;
	localparam int KEEP_W       = 5;
	localparam int KEEP_RESET   = 10;
	localparam int MAX_KEEP_DEF = 16;
	localparam int ADDR_W       = 3;
	localparam int DATA_W       = 32;

	// Register byte addresses
	localparam logic [ADDR_W-1:0] ADDR_KEEP_COUNT = 3'd0;

	// One kept record
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [ID_W-1:0]  author;
		logic [ID_W-1:0]  repo;
	} entry_t;

	// Per-cell control from the top level
	typedef struct packed {
		logic ins;       // insert the incoming record this cycle
		logic drain;     // shift toward rank 0 by one entry
		logic clear;     // drop the entry (limit lowered)
		logic in_range;  // cell index below the active limit
	} cell_ctl_t;

endpackage

@@ hw/rtl/tkl_cell.sv @@
// One cell of the sorted chain: holds one entry and exchanges with its neighbors.
`timescale 1ns / 1ps

module tkl_cell
	import tkl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    new_data,
	input  logic      up_keep,
	input  logic      up_valid,
	input  entry_t    up_data,
	input  logic      dn_valid,
	input  entry_t    dn_data,
	output logic      valid,
	output entry_t    data,
	output logic      keep
);

	logic   valid_q;
	entry_t data_q;
	logic   take_new;
	logic   take_up;

	// Hold the entry when it is at least as long as the newcomer
	assign keep     = valid_q && (data_q.len >= new_data.len);
	assign take_new = ctl.ins && !keep && up_keep;
	assign take_up  = ctl.ins && !keep && !up_keep;

	// Update the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.drain) begin
			valid_q <= dn_valid;
		end else if (ctl.ins) begin
			if (keep) begin
				valid_q <= ctl.in_range;
			end else if (up_keep) begin
				valid_q <= ctl.in_range;
			end else begin
				valid_q <= up_valid && ctl.in_range;
			end
		end
	end

	// Load the payload from the newcomer or a neighbor
	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			data_q <= dn_data;
		end else if (take_new) begin
			data_q <= new_data;
		end else if (take_up) begin
			data_q <= up_data;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

@@ hw/rtl/top_k_by_length_tracker.sv @@
// Top-k by length tracker: a non-final record is accepted and the chain inserts it in place.
// A final record is inserted likewise; then, while the result register is free, the list
// leaves one entry per cycle from cell 0 as the chain shifts toward it; records are stalled
// until the last entry is loaded, and each result is held in a result register.
// Reset (arst_n low) empties the list and sets keep_count to 10.
`timescale 1ns / 1ps

module top_k_by_length_tracker
	import tkl_pkg::*;
#(
	parameter int MAX_KEEP = MAX_KEEP_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	// record channel
	input  logic               rec_valid,
	output logic               rec_stall,
	input  logic [LEN_W-1:0]   message_length,
	input  logic [ID_W-1:0]    writer_id,
	input  logic [ID_W-1:0]    repository_id,
	input  logic               final_record,
	// result channel
	output logic               res_valid,
	input  logic               res_stall,
	output logic [RANK_W-1:0]  rank,
	output logic [LEN_W-1:0]   kept_length,
	output logic [ID_W-1:0]    kept_author,
	output logic [ID_W-1:0]    kept_repository,
	output logic               end_of_list
);

	localparam int LIM_W = $clog2(MAX_KEEP + 1);

	// Clamp a keep count to 1..MAX_KEEP
	function automatic logic [LIM_W-1:0] clamp_limit(input logic [KEEP_W-1:0] kc);
		logic [LIM_W-1:0] r;
		if (kc == '0) begin
			r = LIM_W'(1);
		end else if (32'(kc) > MAX_KEEP) begin
			r = LIM_W'(MAX_KEEP);
		end else begin
			r = LIM_W'(kc);
		end
		return r;
	endfunction

	logic [KEEP_W-1:0] keep_count_q;
	logic [LIM_W-1:0]  limit;
	logic [LIM_W-1:0]  new_limit;
	logic              cfg_we;
	logic              accept;
	logic              drain_q;
	logic              step;
	logic [RANK_W-1:0] rank_q;
	logic              res_valid_q;
	logic [RANK_W-1:0] res_rank_q;
	entry_t            res_data_q;
	logic              res_end_q;
	entry_t            new_data;

	logic              valid_w [MAX_KEEP];
	entry_t            data_w  [MAX_KEEP];
	logic              keep_w  [MAX_KEEP];
	cell_ctl_t         ctl_w   [MAX_KEEP];

	// Configuration register
	assign pready    = 1'b1;
	assign cfg_we    = psel && penable && pwrite && (paddr == ADDR_KEEP_COUNT);
	assign new_limit = clamp_limit(pwdata[KEEP_W-1:0]);
	assign limit     = clamp_limit(keep_count_q);
	assign prdata    = (paddr == ADDR_KEEP_COUNT) ? DATA_W'(keep_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= KEEP_W'(KEEP_RESET);
		end else if (cfg_we) begin
			keep_count_q <= pwdata[KEEP_W-1:0];
		end
	end

	// Record intake
	assign rec_stall = drain_q;
	assign accept    = rec_valid && !rec_stall;
	assign new_data  = '{len: message_length, author: writer_id, repo: repository_id};

	// During an unload, take one entry whenever the result register is free
	assign step = drain_q && (!res_valid_q || !res_stall);

	// Chain of cells
	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		assign ctl_w[i] = '{
			ins:      accept,
			drain:    step,
			clear:    cfg_we && !(LIM_W'(i) < new_limit),
			in_range: LIM_W'(i) < limit
		};

		tkl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_w[i]),
			.new_data (new_data),
			.up_keep  ((i == 0) ? 1'b1 : keep_w[(i == 0) ? 0 : i - 1]),
			.up_valid ((i == 0) ? 1'b0 : valid_w[(i == 0) ? 0 : i - 1]),
			.up_data  ((i == 0) ? entry_t'('0) : data_w[(i == 0) ? 0 : i - 1]),
			.dn_valid ((i == MAX_KEEP - 1) ? 1'b0 : valid_w[(i == MAX_KEEP - 1) ? i : i + 1]),
			.dn_data  ((i == MAX_KEEP - 1) ? entry_t'('0) :
			           data_w[(i == MAX_KEEP - 1) ? i : i + 1]),
			.valid    (valid_w[i]),
			.data     (data_w[i]),
			.keep     (keep_w[i])
		);
	end

	// Drain control and rank counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			rank_q  <= '0;
		end else if (accept && final_record) begin
			drain_q <= 1'b1;
			rank_q  <= '0;
		end else if (step) begin
			rank_q <= rank_q + RANK_W'(1);
			if (!valid_w[1]) begin
				drain_q <= 1'b0;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (step) begin
			res_rank_q <= rank_q;
			res_data_q <= data_w[0];
			res_end_q  <= !valid_w[1];
		end
	end

	assign res_valid       = res_valid_q;
	assign rank            = res_rank_q;
	assign kept_length     = res_data_q.len;
	assign kept_author     = res_data_q.author;
	assign kept_repository = res_data_q.repo;
	assign end_of_list     = res_end_q;

endmodule

@@ hw/rtl/tkl_checker.sv @@
// Port-level checker for the top-k length tracker, bound to the top level.
`timescale 1ns / 1ps
`include "top_k_by_length_tracker_assert.svh"

module tkl_checker
	import tkl_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              rec_valid,
	input logic              rec_stall,
	input logic              final_record,
	input logic              res_valid,
	input logic              res_stall,
	input logic [RANK_W-1:0] rank,
	input logic [LEN_W-1:0]  kept_length,
	input logic              end_of_list
);

	// A stalled result holds
	`TKL_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(rank) && $stable(kept_length) && $stable(end_of_list), "stalled result changed")

	// A final record starts the unload
	`TKL_ASSERT_NEXT(a_final_busy, rec_valid && !rec_stall && final_record, rec_stall, "no stall after final record")

	// Records wait while the list is still leaving
	`TKL_ASSERT(a_busy_mid_list, (res_valid && !end_of_list) |-> rec_stall, "record taken mid list")

	// Entries follow back to back with rising rank
	`TKL_ASSERT_NEXT(a_rank_next, res_valid && !res_stall && !end_of_list, res_valid && (rank == RANK_W'($past(rank) + RANK_W'(1))), "rank sequence broken")

	// Lengths come out in non-increasing order
	`TKL_ASSERT_NEXT(a_len_order, res_valid && !res_stall && !end_of_list, kept_length <= $past(kept_length), "lengths not descending")

endmodule

bind top_k_by_length_tracker tkl_checker u_tkl_checker (.*);
